FILE: rtl/bhq_pkg.sv
// shared types and codes for the sorted-row max-priority queue
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

  localparam int DataW   = 32;
  localparam int CountW  = 11;
  localparam int StatusW = 2;
  localparam int OutW    = 48;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  // link from one cell to the next one down the row
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             gt;
  } bhq_link_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } bhq_op_t;

endpackage

`default_nettype wire

FILE: rtl/binary_max_heap_queue_top.sv
// top level of the max-priority queue built as a row of sorted cells
//
//  port group   dir  fields (low bit up)
//  s_axis       in   tuser: cmd; tdata: value[31:0]
//  m_axis       out  tdata: top_value[31:0], entry_count[42:32], status[44:43]
//
// one word is taken per cycle; its result is shown on the next cycle
// every moved cell updates in the accept cycle: a push shifts the smaller part of
// the row down by one, a pop shifts the whole row up by one
// the word count sits in one register; the cell contents need no reset
// a stalled result holds the input side until it is taken
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue_top
  import bhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DataW-1:0]  s_tdata,   // value
  input  wire logic              s_tuser,   // cmd
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OutW-1:0]        m_tdata    // top_value, entry_count, status, zero pad
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [StatusW-1:0] status;
  logic [StatusW-1:0] status_next;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  bhq_op_t            op;
  bhq_link_t          links [CAPACITY];
  logic [CW+CountW-1:0] count_ext;
  logic [DataW-1:0]   top_value;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    op.push     = accept && (s_tuser == CMD_PUSH) && !is_full;
    op.pop      = accept && (s_tuser == CMD_POP) && !is_empty;
    count_next  = count;
    status_next = STATUS_OK;
    if (s_tuser == CMD_PUSH) begin
      if (is_full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bhq_link_t        prev_link;
    logic [DataW-1:0] next_data;
    if (i == 0) begin : g_head
      assign prev_link = '0;
    end else begin : g_body
      assign prev_link = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = links[i].data;
    end else begin : g_mid
      assign next_data = links[i+1].data;
    end
    bhq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occupied  (count > CW'(i)),
      .value     (s_tdata),
      .prev_link (prev_link),
      .next_data (next_data),
      .link      (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      status   <= STATUS_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        status   <= status_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign count_ext = {{CountW{1'b0}}, count};
  assign top_value = is_empty ? '0 : links[0].data;
  assign m_tdata   = {{(OutW - DataW - CountW - StatusW){1'b0}},
                      status, count_ext[CountW-1:0], top_value};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("word count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == STATUS_FULL) |-> is_full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == STATUS_EMPTY) |-> is_empty && (top_value == '0))
    else $error("empty status with words held");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    op.pop |=> count == $past(count) - 1'b1)
    else $error("pop did not drop one word");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    op.push |=> count == $past(count) + 1'b1)
    else $error("push did not add one word");

endmodule

`default_nettype wire

FILE: rtl/bhq_cell.sv
// one slot of the sorted cell row, largest value at cell zero
`timescale 1ns / 1ps
`default_nettype none

module bhq_cell
  import bhq_pkg::*;
(
  input  wire logic             clk,
  input  wire bhq_op_t          op,
  input  wire logic             occupied,
  input  wire logic [DataW-1:0] value,
  input  wire bhq_link_t        prev_link,
  input  wire logic [DataW-1:0] next_data,
  output bhq_link_t             link
);

  logic [DataW-1:0] data;
  logic             gt;

  // an empty slot loses to any incoming value
  always_comb begin
    gt = !occupied || ($signed(value) > $signed(data));
    link.data = data;
    link.gt = gt;
  end

  always_ff @(posedge clk) begin
    if (op.push && gt) begin
      data <= prev_link.gt ? prev_link.data : value;
    end else if (op.pop) begin
      data <= next_data;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_binary_max_heap_queue_top.sv
// self-checking testbench for the max-priority queue: stream driver, heap predictor, monitor
`timescale 1ns / 1ps

module tb_binary_max_heap_queue_top;
  import bhq_pkg::*;

  localparam int Capacity   = 1024;
  localparam int CycleLimit = 200000;
  localparam int CountLo    = DataW;
  localparam int StatusLo   = DataW + CountW;
  localparam int PadLo      = DataW + CountW + StatusW;

  typedef struct {
    logic             cmd;
    logic [DataW-1:0] value;
  } queue_op_t;

  typedef struct {
    logic [DataW-1:0]   top;
    logic [CountW-1:0]  count;
    logic [StatusW-1:0] status;
  } queue_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DataW-1:0] s_tdata = '0;
  logic s_tuser = CMD_PUSH;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;

  binary_max_heap_queue_top #(
    .CAPACITY(Capacity)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  queue_op_t     pending_ops[$];
  queue_answer_t expected_answers[$];

  logic signed [DataW-1:0] heap_vals[Capacity];
  int heap_fill = 0;
  int gen_fill = 0;
  int errors = 0;
  int cycles = 0;
  int n_push = 0, n_pop = 0, n_pop_empty = 0, n_push_full = 0, n_results = 0, peak_fill = 0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0;

  function automatic queue_answer_t apply_heap_op(input logic cmd, input logic [DataW-1:0] value);
    queue_answer_t ans;
    int pos, parent, best, lc, rc;
    logic signed [DataW-1:0] tmp;
    ans.status = STATUS_OK;
    if (cmd == CMD_PUSH) begin
      if (heap_fill >= Capacity) begin
        ans.status = STATUS_FULL;
      end else begin
        heap_vals[heap_fill] = value;
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(heap_vals[pos] > heap_vals[parent])) break;
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[parent];
          heap_vals[parent] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        ans.status = STATUS_EMPTY;
      end else begin
        heap_fill--;
        heap_vals[0] = heap_vals[heap_fill];
        pos = 0;
        while (pos < heap_fill) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < heap_fill && heap_vals[lc] > heap_vals[best]) best = lc;
          if (rc < heap_fill && heap_vals[rc] > heap_vals[best]) best = rc;
          if (best == pos) break;
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[best];
          heap_vals[best] = tmp;
          pos = best;
        end
      end
    end
    ans.top = (heap_fill > 0) ? heap_vals[0] : '0;
    ans.count = heap_fill[CountW-1:0];
    return ans;
  endfunction

  task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, field, got, want);
  endtask

  task automatic add_op(input logic cmd, input logic [DataW-1:0] value);
    queue_op_t op;
    op.cmd = cmd;
    op.value = value;
    pending_ops = {pending_ops, op};
    if (cmd == CMD_PUSH && gen_fill < Capacity) gen_fill++;
    if (cmd == CMD_POP && gen_fill > 0) gen_fill--;
  endtask

  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 7) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_mixed(input int n, input int push_pct);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= push_pct) add_op(CMD_PUSH, pick_value());
      else add_op(CMD_POP, $urandom);
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    int i;
    // pops on empty, extremes, ties at the top and below it, drain past empty
    add_op(CMD_POP, 32'hffff_ffff);
    add_op(CMD_POP, 32'h0000_0000);
    add_op(CMD_PUSH, 32'h7fff_ffff);
    add_op(CMD_PUSH, 32'h8000_0000);
    add_op(CMD_PUSH, 32'h0000_0000);
    add_op(CMD_PUSH, 32'hffff_ffff);
    add_op(CMD_PUSH, 32'h0000_0001);
    add_op(CMD_PUSH, 32'h0000_0005);
    add_op(CMD_PUSH, 32'h0000_0005);
    add_op(CMD_PUSH, 32'h0000_0005);
    add_op(CMD_PUSH, 32'h7fff_ffff);
    for (i = 0; i < 10; i++) add_op(CMD_POP, $urandom);

    add_mixed(60, 60);
    while (gen_fill < Capacity) begin
      if ($urandom_range(0, 49) == 0) add_op(CMD_POP, $urandom);
      else add_op(CMD_PUSH, pick_value());
    end
    for (i = 0; i < 6; i++) add_op(CMD_PUSH, pick_value());
    for (i = 0; i < 10; i++) begin
      add_op(CMD_POP, $urandom);
      add_op(CMD_PUSH, pick_value());
      add_op(CMD_PUSH, pick_value());
    end
    add_mixed(40, 35);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_answers.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_answers.size());
    end
    $display("covered %0d pushes (%0d rejected on full) and %0d pops (%0d rejected on empty)",
             n_push, n_push_full, n_pop, n_pop_empty);
    $display("%0d results checked, peak fill %0d of %0d", n_results, peak_fill, Capacity);
    if (errors == 0) begin
      $display("[binary_max_heap_queue_top] OK");
    end else begin
      $display("[binary_max_heap_queue_top] ERROR");
    end
    $finish;
  end

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    queue_op_t op;
    queue_answer_t ans;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ans = apply_heap_op(s_tuser, s_tdata);
        expected_answers = {expected_answers, ans};
        if (s_tuser == CMD_PUSH) n_push++;
        else n_pop++;
        if (ans.status == STATUS_FULL) n_push_full++;
        if (ans.status == STATUS_EMPTY) n_pop_empty++;
        if (heap_fill > peak_fill) peak_fill = heap_fill;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= op.cmd;
          s_tdata <= op.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result word under a stall pattern that is picked anew at random
  always @(posedge clk) begin
    queue_answer_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[binary_max_heap_queue_top] ERROR");
      $finish;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[DataW-1:0], '0);
        end else begin
          want = expected_answers.pop_front();
          if (m_tdata[DataW-1:0] !== want.top)
            report_mismatch("top_value", m_tdata[DataW-1:0], want.top);
          if (m_tdata[StatusLo-1:CountLo] !== want.count)
            report_mismatch("entry_count", m_tdata[StatusLo-1:CountLo], want.count);
          if (m_tdata[PadLo-1:StatusLo] !== want.status)
            report_mismatch("status", m_tdata[PadLo-1:StatusLo], want.status);
          if (m_tdata[OutW-1:PadLo] !== '0)
            report_mismatch("pad", m_tdata[OutW-1:PadLo], '0);
        end
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= (cycles % 7) < 2;
        default: m_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

endmodule

FILE: files.f
rtl/bhq_pkg.sv
rtl/bhq_cell.sv
rtl/binary_max_heap_queue_top.sv
bench/tb_binary_max_heap_queue_top.sv
